### rtl/core/string_hash_bucket_index_assert.svh
// Assertion macros for the string hash bucket index block.
`ifndef STRING_HASH_BUCKET_INDEX_ASSERT_SVH
`define STRING_HASH_BUCKET_INDEX_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SHBI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define SHBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/shbi_pkg.sv
// Package with the types, constants and mixing schedule of the string hash block.
`default_nettype none

package shbi_pkg;

  localparam logic [31:0] GOLDEN_WORD   = 32'h9E37_79B9;
  localparam logic [31:0] INIT_RESET    = 32'hDEAD_BEEF;
  localparam int          BUCKET_W      = 17;
  localparam logic [BUCKET_W-1:0] BUCKETS_RESET = 17'd1024;
  localparam logic [31:0] HALF_RANGE    = 32'h7FFF_FFFF;
  localparam logic [3:0]  LAST_BLOCK_POS = 4'd11;
  localparam logic [3:0]  MIX_LAST_STEP  = 4'd8;
  localparam logic [4:0]  DIV_LAST_STEP  = 5'd31;

  localparam int          CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_VALUE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 2'd1;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_present;
    logic       last_of_key;
  } shbi_in_t;

  typedef struct packed {
    logic [31:0] hash_word;
    logic [15:0] bucket_index;
  } shbi_out_t;

  typedef struct packed {
    logic take;
    logic tail;
    logic mix_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } shbi_cmd_t;

  typedef struct packed {
    logic blk_full;
    logic mix_last;
    logic div_last;
  } shbi_sts_t;

  typedef enum logic [1:0] {
    LANE_A = 2'd0,
    LANE_B = 2'd1,
    LANE_C = 2'd2
  } shbi_lane_t;

  typedef struct packed {
    shbi_lane_t lane;
    logic [4:0] amt;
  } shbi_mix_row_t;

  // One row of the mix: the named lane loses the other two and is xored with
  // a shifted copy of the lane updated just before it.
  function automatic shbi_mix_row_t mix_row(input logic [3:0] step);
    shbi_mix_row_t row;
    case (step)
      4'd0: row = '{lane: LANE_A, amt: 5'd13};
      4'd1: row = '{lane: LANE_B, amt: 5'd8};
      4'd2: row = '{lane: LANE_C, amt: 5'd13};
      4'd3: row = '{lane: LANE_A, amt: 5'd12};
      4'd4: row = '{lane: LANE_B, amt: 5'd16};
      4'd5: row = '{lane: LANE_C, amt: 5'd5};
      4'd6: row = '{lane: LANE_A, amt: 5'd3};
      4'd7: row = '{lane: LANE_B, amt: 5'd10};
      4'd8: row = '{lane: LANE_C, amt: 5'd15};
      default: row = '{lane: LANE_A, amt: 5'd0};
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

### rtl/core/shbi_datapath.sv
// Datapath of the string hash block: lanes, byte packing, mix row unit and divider.
`default_nettype none

module shbi_datapath
  import shbi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire shbi_in_t               in_item,
  input  wire shbi_cmd_t              cmd,
  output shbi_sts_t                   sts,
  output shbi_out_t                   out_item
);

  logic [31:0]         lane_a;
  logic [31:0]         lane_b;
  logic [31:0]         lane_c;
  logic [31:0]         init_value;
  logic [BUCKET_W-1:0] bucket_count;
  logic [3:0]          block_pos;
  logic [31:0]         key_length;
  logic [3:0]          mix_cnt;
  logic [4:0]          div_cnt;
  logic [7:0]          pend0;
  logic [7:0]          pend1;
  logic [7:0]          pend2;
  logic [31:0]         dvd;
  logic [BUCKET_W-1:0] rem;

  logic [31:0]         byte_shifted;
  logic [31:0]         tail_word;
  logic [31:0]         reduced;
  shbi_mix_row_t       row;
  logic [31:0]         mx;
  logic [31:0]         my;
  logic [31:0]         mz;
  logic [31:0]         mz_shift;
  logic [31:0]         mixed;
  logic [BUCKET_W:0]   trial;
  logic [BUCKET_W:0]   diff;

  assign byte_shifted = {24'd0, in_item.key_byte} << {block_pos[1:0], 3'b000};

  // Tail bytes sit one byte higher in lane c, leaving the low byte for the length.
  assign tail_word = {(block_pos > 4'd10) ? pend2 : 8'd0,
                      (block_pos > 4'd9)  ? pend1 : 8'd0,
                      (block_pos > 4'd8)  ? pend0 : 8'd0,
                      8'd0};

  assign reduced = (lane_c > HALF_RANGE) ? (lane_c - HALF_RANGE) : lane_c;

  always_comb begin
    row = mix_row(mix_cnt);
    case (row.lane)
      LANE_A: begin
        mx = lane_a; my = lane_b; mz = lane_c;
      end
      LANE_B: begin
        mx = lane_b; my = lane_c; mz = lane_a;
      end
      LANE_C: begin
        mx = lane_c; my = lane_a; mz = lane_b;
      end
      default: begin
        mx = lane_a; my = lane_b; mz = lane_c;
      end
    endcase
    mz_shift = (row.lane == LANE_B) ? (mz << row.amt) : (mz >> row.amt);
    mixed    = (mx - my - mz) ^ mz_shift;
  end

  assign trial = {rem, dvd[31]};
  assign diff  = trial - {1'b0, bucket_count};

  assign sts.blk_full = in_item.byte_present && (block_pos == LAST_BLOCK_POS);
  assign sts.mix_last = (mix_cnt == MIX_LAST_STEP);
  assign sts.div_last = (div_cnt == DIV_LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_a       <= GOLDEN_WORD;
      lane_b       <= GOLDEN_WORD;
      lane_c       <= INIT_RESET;
      init_value   <= INIT_RESET;
      bucket_count <= BUCKETS_RESET;
      block_pos    <= 4'd0;
      key_length   <= 32'd0;
      mix_cnt      <= 4'd0;
      div_cnt      <= 5'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_INIT_VALUE: begin
            init_value <= cfg_data;
            if (key_length == 32'd0) begin
              lane_c <= cfg_data;
            end
          end
          REG_BUCKET_COUNT: bucket_count <= cfg_data[BUCKET_W-1:0];
          default: ;
        endcase
      end

      if (cmd.take && in_item.byte_present) begin
        key_length <= key_length + 32'd1;
        block_pos  <= (block_pos == LAST_BLOCK_POS) ? 4'd0 : block_pos + 4'd1;
        case (block_pos)
          4'd0, 4'd1, 4'd2, 4'd3: lane_a <= lane_a + byte_shifted;
          4'd4, 4'd5, 4'd6, 4'd7: lane_b <= lane_b + byte_shifted;
          LAST_BLOCK_POS: lane_c <= lane_c + {in_item.key_byte, pend2, pend1, pend0};
          default: ;
        endcase
      end

      if (cmd.tail) begin
        lane_c <= lane_c + tail_word + key_length;
      end

      if (cmd.mix_step) begin
        mix_cnt <= sts.mix_last ? 4'd0 : mix_cnt + 4'd1;
        case (row.lane)
          LANE_A:  lane_a <= mixed;
          LANE_B:  lane_b <= mixed;
          LANE_C:  lane_c <= mixed;
          default: ;
        endcase
      end

      if (cmd.div_load) begin
        div_cnt <= 5'd0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 5'd1;
      end

      if (cmd.out_load) begin
        lane_a     <= GOLDEN_WORD;
        lane_b     <= GOLDEN_WORD;
        lane_c     <= init_value;
        block_pos  <= 4'd0;
        key_length <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_item.byte_present) begin
      case (block_pos)
        4'd8:    pend0 <= in_item.key_byte;
        4'd9:    pend1 <= in_item.key_byte;
        4'd10:   pend2 <= in_item.key_byte;
        default: ;
      endcase
    end

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    if (cmd.div_load) begin
      dvd <= reduced;
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= (trial >= {1'b0, bucket_count}) ? diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
    end

    if (cmd.out_load) begin
      out_item.hash_word    <= lane_c;
      out_item.bucket_index <= (bucket_count == '0) ? 16'd0 : rem[15:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/shbi_ctrl.sv
// Controller state machine of the string hash block.
`default_nettype none

module shbi_ctrl
  import shbi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire shbi_sts_t sts,
  output shbi_cmd_t      cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TAIL  = 6'b000010,
    ST_MIX   = 6'b000100,
    ST_DLOAD = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } shbi_state_t;

  shbi_state_t state;
  shbi_state_t state_next;
  logic        final_mix;
  logic        final_mix_next;
  logic        last_held;
  logic        last_held_next;
  logic        accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    final_mix_next = final_mix;
    last_held_next = last_held;
    cmd            = '0;
    cmd.take       = accept;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (sts.blk_full) begin
            state_next     = ST_MIX;
            final_mix_next = 1'b0;
            last_held_next = in_last;
          end else if (in_last) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        cmd.tail       = 1'b1;
        final_mix_next = 1'b1;
        state_next     = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix_step = 1'b1;
        if (sts.mix_last) begin
          if (final_mix) begin
            state_next = ST_DLOAD;
          end else if (last_held) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      final_mix <= 1'b0;
      last_held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      final_mix <= final_mix_next;
      last_held <= last_held_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/string_hash_bucket_index.sv
// Top level of the string hash bucket index block: controller, datapath, assertions.
//
// Usage: a key enters one byte per input transaction on in_item (key_byte,
// byte_present, last_of_key) under in_valid/in_ready. A transaction with
// byte_present low and last_of_key low does nothing; with last_of_key high it
// ends the key, which may then be empty. Each key yields exactly one output
// transaction on out_item (hash_word, bucket_index) under out_valid/out_ready.
// Configuration: cfg_write with cfg_index 0 loads init_value, index 1 loads
// bucket_count; the user must make writes only while the block is idle (unenforced).
// Input: an ordinary byte is taken without a mix. The twelfth byte of a block
// starts the mix, one row per cycle through a shared row unit, with in_ready low.
// Sequence: after the last transaction of a key come the tail add, the final
// mix, the divider load, the remainder steps and the output load, in order;
// the bit-serial divider that forms the remainder is the longest step.
// Reset: rst is synchronous; lanes, length and registers return to their reset
// values and no result is pending. There is no clearing pass.
// Stall: a finished result waits in the output register; the next key's bytes
// are taken meanwhile, and a second result waits in the datapath until the
// first has been delivered.
`default_nettype none

`include "string_hash_bucket_index_assert.svh"

module string_hash_bucket_index
  import shbi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire shbi_in_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output shbi_out_t                   out_item
);

  shbi_cmd_t cmd;
  shbi_sts_t sts;

  // The controller sequences the byte take, mix rows, tail add, division and output load.
  shbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_item.last_of_key),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the lanes, configuration registers and output register.
  shbi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

  // A result is loaded only into a free or draining output register.
  `SHBI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  // Output valid rises only right after a result load.
  `SHBI_ASSERT_SAME(a_valid_source, $rose(out_valid), $past(cmd.out_load), "stray out_valid")
  // No transaction is taken while the mix unit or divider is working.
  `SHBI_ASSERT_SAME(a_busy_block, in_ready, !(cmd.mix_step || cmd.div_step || cmd.tail),
                    "input taken while busy")
  // Division steps always start right after the divider load, with input blocked.
  `SHBI_ASSERT_NEXT(a_div_follows, cmd.div_load, cmd.div_step && !in_ready, "divider not started")

endmodule

`default_nettype wire
